// ===== hdl/cascaded_biquad_filter_macros.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef CASCADED_BIQUAD_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset.
`define CBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/cbq_pkg.sv =====
package cbq_pkg;

    // Internal section value width and coefficient width
    localparam int DATA_W   = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = DATA_W + COEF_W;
    localparam int ACC_W    = PROD_W + 3;

    localparam int MAX_SECTIONS = 4;
    localparam int SEC_W        = 2;
    localparam int FF_W         = 3 * COEF_W;
    localparam int FB_W         = 2 * COEF_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FF_W;

    localparam int DEF_SECTION_COUNT      = 4;
    localparam int DEF_SAMPLE_BITS        = 24;
    localparam int DEF_COEF_FRACTION_BITS = 14;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One section's history: last two inputs and last two outputs
    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
    } delay_row_t;

endpackage

// ===== hdl/cascaded_biquad_filter.sv =====
// Four-section (SECTION_COUNT) direct-form-I biquad cascade with Q2.14-style coefficients
// (COEF_FRACTION_BITS fraction bits). One 16x32 multiplier and one accumulator are shared by
// all twenty products; a section runs five products, a drain add, then a round/saturate
// and history update. From one acceptance to the earliest next one, a sample passes the
// accepting step, the steps of each section in turn and one output step. The result beat
// is offered in the same cycle that s_tready returns. The output step holds, and s_tready
// stays low, while the previous result still waits in the output register, so a stalled
// m_tready delays the next acceptance by the stall. Coefficients are written through
// cfg_wr_en/cfg_index/cfg_data; the user must write them only while idle, as the block
// itself does not enforce it. Index 2s is section s+1's b0,b1,b2, index 2s+1 its added
// feedback f1,f2. Section outputs saturate to 32 bits, the final sample to SAMPLE_BITS;
// tlast travels alongside unchanged.
`include "cascaded_biquad_filter_macros.svh"

module cascaded_biquad_filter
    import cbq_pkg::*;
#(
    parameter int SECTION_COUNT      = DEF_SECTION_COUNT,
    parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS,
    parameter int COEF_FRACTION_BITS = DEF_COEF_FRACTION_BITS,
    localparam int TDATA_W           = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // [SAMPLE_BITS-1:0] sample_in
    input  logic                  s_tlast,    // frame_end_in

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // [SAMPLE_BITS-1:0] sample_out
    output logic                  m_tlast,    // frame_end_out

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_MAC   = 3'd1;
    localparam logic [STATE_W-1:0] S_DRAIN = 3'd2;
    localparam logic [STATE_W-1:0] S_ROUND = 3'd3;
    localparam logic [STATE_W-1:0] S_OUT   = 3'd4;

    localparam int TAP_W = 3;
    localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_F1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_F2 = 3'd4;

    localparam logic CFG_SEL_FEEDBACK = 1'b1;

    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTION_COUNT - 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRACTION_BITS - 1);
    localparam logic signed [ACC_W-1:0] SEC_MAX_EXT = ACC_W'(DATA_MAX);
    localparam logic signed [ACC_W-1:0] SEC_MIN_EXT = ACC_W'(DATA_MIN);

    localparam logic signed [DATA_W-1:0] OUT_MAX =
        DATA_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [DATA_W-1:0] OUT_MIN =
        DATA_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Control
    logic [STATE_W-1:0] state_reg, state_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Coefficients and section history
    logic [FF_W-1:0]    ff_reg [MAX_SECTIONS];
    logic [FB_W-1:0]    fb_reg [MAX_SECTIONS];
    delay_row_t         delay_reg [MAX_SECTIONS];

    // Datapath
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     last_reg, last_next;
    logic [SAMPLE_BITS-1:0]   m_sample_reg, m_sample_next;
    logic                     m_tlast_reg, m_tlast_next;

    logic [FF_W-1:0]          ff_cur;
    logic [FB_W-1:0]          fb_cur;
    delay_row_t               row_cur;
    delay_row_t               row_new;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [DATA_W-1:0] op_sel;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_shift;
    logic signed [DATA_W-1:0] sec_y;
    logic signed [DATA_W-1:0] out_sat;
    logic                     accept;
    logic                     out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign ff_cur  = ff_reg[sec_reg];
    assign fb_cur  = fb_reg[sec_reg];
    assign row_cur = delay_reg[sec_reg];

    // Operand selection for the shared multiplier
    always_comb begin
        case (tap_reg)
            TAP_B0: begin
                coef_sel = ff_cur[COEF_W-1:0];
                op_sel   = cur_reg;
            end
            TAP_B1: begin
                coef_sel = ff_cur[2*COEF_W-1:COEF_W];
                op_sel   = row_cur.x1;
            end
            TAP_B2: begin
                coef_sel = ff_cur[3*COEF_W-1:2*COEF_W];
                op_sel   = row_cur.x2;
            end
            TAP_F1: begin
                coef_sel = fb_cur[COEF_W-1:0];
                op_sel   = row_cur.y1;
            end
            TAP_F2: begin
                coef_sel = fb_cur[2*COEF_W-1:COEF_W];
                op_sel   = row_cur.y2;
            end
            default: begin
                coef_sel = '0;
                op_sel   = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(coef_sel) * PROD_W'(op_sel);

    // Round half up, floor-shift, then clamp to the section width
    always_comb begin
        rnd_sum   = acc_reg + ROUND_HALF;
        rnd_shift = rnd_sum >>> COEF_FRACTION_BITS;
        if (rnd_shift > SEC_MAX_EXT) begin
            sec_y = DATA_MAX;
        end else if (rnd_shift < SEC_MIN_EXT) begin
            sec_y = DATA_MIN;
        end else begin
            sec_y = rnd_shift[DATA_W-1:0];
        end
    end

    always_comb begin
        row_new.x1 = cur_reg;
        row_new.x2 = row_cur.x1;
        row_new.y1 = sec_y;
        row_new.y2 = row_cur.y1;
    end

    always_comb begin
        if (cur_reg > OUT_MAX) begin
            out_sat = OUT_MAX;
        end else if (cur_reg < OUT_MIN) begin
            out_sat = OUT_MIN;
        end else begin
            out_sat = cur_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        sec_next      = sec_reg;
        tap_next      = tap_reg;
        cur_next      = cur_reg;
        acc_next      = acc_reg;
        last_next     = last_reg;
        m_sample_next = m_sample_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cur_next   = DATA_W'(signed'(s_tdata[SAMPLE_BITS-1:0]));
                    last_next  = s_tlast;
                    acc_next   = '0;
                    sec_next   = '0;
                    tap_next   = TAP_B0;
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                // the product issued last cycle is ready from the second tap on
                if (tap_reg != TAP_B0) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (tap_reg == TAP_F2) begin
                    tap_next   = TAP_B0;
                    state_next = S_DRAIN;
                end else begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            S_DRAIN: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cur_next = sec_y;
                acc_next = '0;
                if (sec_reg == SEC_LAST) begin
                    state_next = S_OUT;
                end else begin
                    sec_next   = sec_reg + SEC_W'(1);
                    state_next = S_MAC;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_sample_next = out_sat[SAMPLE_BITS-1:0];
                    m_tlast_next  = last_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sec_reg      <= '0;
            tap_reg      <= TAP_B0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sec_reg      <= sec_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Coefficient registers reset to identity sections
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                ff_reg[i] <= FF_W'(1) << COEF_FRACTION_BITS;
                fb_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index[0] == CFG_SEL_FEEDBACK) begin
                fb_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data[FB_W-1:0];
            end else begin
                ff_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data[FF_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                delay_reg[i] <= '0;
            end
        end else if (state_reg == S_ROUND) begin
            delay_reg[sec_reg] <= row_new;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        last_reg     <= last_next;
        m_sample_reg <= m_sample_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_sample_reg);
    assign m_tlast  = m_tlast_reg;

    `CBQ_ASSERT_NXT(a_accept_starts_mac, aclk, aresetn, accept,
        state_reg == S_MAC && sec_reg == '0 && tap_reg == TAP_B0,
        "accepted beat did not start the first section")
    `CBQ_ASSERT_IMP(a_drain_after_last_tap, aclk, aresetn, state_reg == S_DRAIN,
        $past(state_reg) == S_MAC && $past(tap_reg) == TAP_F2,
        "drain entered before all five products were issued")
    `CBQ_ASSERT_IMP(a_result_from_out, aclk, aresetn, $rose(m_tvalid_reg),
        $past(state_reg) == S_OUT,
        "result beat raised outside the output step")
    `CBQ_ASSERT_IMP(a_no_accept_while_busy, aclk, aresetn, state_reg != S_IDLE,
        !accept, "input beat taken while a sample is in work")

endmodule
